// ===== design/rrpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_pkg
// shared types and constants of the ring reduce progress tracker
// ----------------------------------------------------------------------------
package rrpt_pkg;

  localparam int unsigned MaxRanks  = 64;
  localparam int unsigned RankW     = $clog2(MaxRanks);
  localparam int unsigned RingW     = 7;
  localparam int unsigned BytesW    = 32;
  localparam int unsigned FlowW     = 16;
  localparam int unsigned StepW     = 6;
  localparam int unsigned EntryW    = BytesW + StepW;
  localparam int unsigned CfgDataW  = 32;

  // input opcodes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_OTHER  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_RANKS  = 2'd0,
    CFG_SEGMENT    = 2'd1,
    CFG_ROOT_RANK  = 2'd2,
    CFG_BASE_FLOW  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RUNNING = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MOD,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_EMIT
  } state_e;

  // event codes of a result
  localparam logic EV_SEND     = 1'b0;
  localparam logic EV_COMPLETE = 1'b1;

  // one entry of the per-rank store
  typedef struct packed {
    logic [BytesW-1:0] bytes;
    logic [StepW-1:0]  steps;
  } entry_t;

endpackage
`default_nettype wire

// ===== design/rrpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rrpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/ring_reduce_progress_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_reduce_progress_tracker_core
// follows a ring reduce: per-rank byte counters and step counts in one ram,
// emits send commands per step and one completion when the root finishes
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_ready_o   opcode, dest_rank, effective_bytes,
//                                                 packet_bytes
//  out       source     out_valid_o / out_ready_i event_res, sender_rank, target_rank,
//                                                 step_index, flow_id, last_of_run
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  flow: a data packet is read from the ram on acceptance, then modified and
//  written back, then emitted if it owes a result; a rank that finishes with
//  the root inside the ring first reads and checks the root entry through the
//  same ram port. a start walks the ring, one send a cycle while out is free.
//  reset: the per-entry valid bits clear at once, so no clearing pass is needed;
//  a start clears them the same way.
//  stalls: a held result blocks the next result load, and input while the fsm waits
//  to load it; the output register parts the two sides. the config port is always ready.
// ----------------------------------------------------------------------------
module ring_reduce_progress_tracker_core
  import rrpt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [RankW-1:0]    dest_rank_i,
  input  wire logic [BytesW-1:0]   effective_bytes_i,
  input  wire logic [BytesW-1:0]   packet_bytes_i,
  // results
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                event_res_o,
  output      logic [RankW-1:0]    sender_rank_o,
  output      logic [RankW-1:0]    target_rank_o,
  output      logic [StepW-1:0]    step_index_o,
  output      logic [FlowW-1:0]    flow_id_o,
  output      logic                last_of_run_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [RingW-1:0]  num_ranks_q;
  logic [BytesW-1:0] segment_q;
  logic [RankW-1:0]  root_rank_q;
  logic [FlowW-1:0]  base_flow_q;

  // control
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [MaxRanks-1:0] vld_q, vld_d;
  logic [RankW-1:0]    cnt_q, cnt_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                emit_done_q, emit_done_d;

  // captured item
  logic [RankW-1:0]  dest_q, dest_d;
  logic [BytesW-1:0] eff_q, eff_d;
  logic [BytesW-1:0] pkt_q, pkt_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              ev_q, ev_d;
  logic [RankW-1:0]  snd_q, snd_d;
  logic [RankW-1:0]  tgt_q, tgt_d;
  logic [StepW-1:0]  ostep_q, ostep_d;
  logic [FlowW-1:0]  flow_q, flow_d;
  logic              last_q, last_d;

  // ram port
  logic              ram_we;
  logic [RankW-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [RankW-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic [RingW-1:0]  ring_n;
  logic [StepW-1:0]  total;

  // datapath terms of the modify step
  entry_t            cur;
  logic [StepW-1:0]  root_steps;
  logic              rank_done;
  logic [BytesW-1:0] add_bytes;
  logic [BytesW:0]   sum_wide;
  logic [BytesW-1:0] sum_sat;
  logic              seg_hit;
  logic [StepW-1:0]  next_step;
  logic              root_in_ring;
  logic              start_last;

  // send fields built for the result register
  logic [RankW-1:0]  s_rank;
  logic [StepW-1:0]  s_step;
  logic [RankW-1:0]  s_tgt;

  // ring size clamped to [2, MaxRanks]
  always_comb begin
    if (num_ranks_q < RingW'(2)) begin
      ring_n = RingW'(2);
    end else if (num_ranks_q > RingW'(MaxRanks)) begin
      ring_n = RingW'(MaxRanks);
    end else begin
      ring_n = num_ranks_q;
    end
  end
  assign total = StepW'(ring_n - RingW'(1));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ranks_q <= RingW'(2);
      segment_q   <= BytesW'(1);
      root_rank_q <= '0;
      base_flow_q <= FlowW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_RANKS: num_ranks_q <= cfg_data_i[RingW-1:0];
        CFG_SEGMENT:   segment_q   <= cfg_data_i[BytesW-1:0];
        CFG_ROOT_RANK: root_rank_q <= cfg_data_i[RankW-1:0];
        CFG_BASE_FLOW: base_flow_q <= cfg_data_i[FlowW-1:0];
      endcase
    end
  end

  // per-rank store: byte counter and step count
  rrpt_ram #(
    .WIDTH(EntryW),
    .DEPTH(MaxRanks)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // entries never written since the last clear read as zero
  assign cur        = vld_q[dest_q] ? ram_rdata : '0;
  assign root_steps = vld_q[root_rank_q] ? ram_rdata.steps : '0;
  assign rank_done  = cur.steps >= total;
  assign add_bytes  = (eff_q == '0) ? pkt_q : eff_q;
  assign sum_wide   = {1'b0, cur.bytes} + {1'b0, add_bytes};
  assign sum_sat    = sum_wide[BytesW] ? '1 : sum_wide[BytesW-1:0];
  assign seg_hit    = sum_sat >= segment_q;
  assign next_step  = cur.steps + StepW'(1);
  assign root_in_ring = {1'b0, root_rank_q} < ring_n;
  assign start_last   = ({1'b0, cnt_q} == (ring_n - RingW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (opcode_e'(opcode_i) == OP_START) begin
            state_d = ST_START;
          end else if (opcode_e'(opcode_i) == OP_DATA && phase_q == PH_RUNNING &&
                       {1'b0, dest_rank_i} < ring_n) begin
            state_d = ST_MOD;
          end
        end
      end
      ST_START: begin
        if (out_free && start_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        priority if (rank_done || !seg_hit) begin
          state_d = ST_IDLE;
        end else if (next_step < total) begin
          state_d = ST_EMIT;
        end else if (root_in_ring) begin
          state_d = ST_ROOT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT_RD: state_d = ST_ROOT_CHK;
      ST_ROOT_CHK: begin
        state_d = (root_steps >= total) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // send fields: start walks the ring counter, a packet uses its rank
  assign s_rank = (state_q == ST_START) ? cnt_q : dest_q;
  assign s_step = (state_q == ST_START) ? '0 : step_q;
  assign s_tgt  = (s_rank == '0) ? RankW'(ring_n - RingW'(1)) : s_rank - RankW'(1);

  // datapath, ram control and result loads
  always_comb begin
    phase_d     = phase_q;
    vld_d       = vld_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    emit_done_d = emit_done_q;
    dest_d      = dest_q;
    eff_d       = eff_q;
    pkt_d       = pkt_q;
    ram_we      = 1'b0;
    ram_waddr   = dest_q;
    ram_wdata   = '0;
    ram_raddr   = dest_rank_i;
    out_load    = 1'b0;
    ev_d        = EV_SEND;
    snd_d       = s_rank;
    tgt_d       = s_tgt;
    ostep_d     = s_step;
    flow_d      = base_flow_q + FlowW'(s_step);
    last_d      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dest_d = dest_rank_i;
          eff_d  = effective_bytes_i;
          pkt_d  = packet_bytes_i;
          if (opcode_e'(opcode_i) == OP_START) begin
            vld_d   = '0;
            phase_d = PH_RUNNING;
            cnt_d   = '0;
          end
        end
      end
      ST_START: begin
        if (out_free) begin
          out_load = 1'b1;
          last_d   = start_last;
          cnt_d    = cnt_q + RankW'(1);
        end
      end
      ST_MOD: begin
        if (!rank_done) begin
          ram_we        = 1'b1;
          vld_d[dest_q] = 1'b1;
          if (seg_hit) begin
            ram_wdata.bytes = '0;
            ram_wdata.steps = next_step;
            step_d          = next_step;
            emit_done_d     = 1'b0;
          end else begin
            ram_wdata.bytes = sum_sat;
            ram_wdata.steps = cur.steps;
          end
        end
      end
      ST_ROOT_RD: begin
        ram_raddr = root_rank_q;
      end
      ST_ROOT_CHK: begin
        if (root_steps >= total) begin
          phase_d     = PH_DONE;
          emit_done_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_done_q) begin
            ev_d    = EV_COMPLETE;
            snd_d   = '0;
            tgt_d   = '0;
            ostep_d = '0;
            flow_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      vld_q       <= '0;
      cnt_q       <= '0;
      emit_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      vld_q       <= vld_d;
      cnt_q       <= cnt_d;
      emit_done_q <= emit_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dest_q <= dest_d;
    eff_q  <= eff_d;
    pkt_q  <= pkt_d;
    if (out_load) begin
      ev_q    <= ev_d;
      snd_q   <= snd_d;
      tgt_q   <= tgt_d;
      ostep_q <= ostep_d;
      flow_q  <= flow_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign sender_rank_o = snd_q;
  assign target_rank_o = tgt_q;
  assign step_index_o  = ostep_q;
  assign flow_id_o     = flow_q;
  assign last_of_run_o = last_q;

  // checks
  a_we_only_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_MOD)
    else $error("ram written outside the modify step");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && opcode_e'(opcode_i) == OP_START) |=> phase_q == PH_RUNNING && vld_q == '0)
    else $error("start did not clear the store and enter running");

  a_complete_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ev_d == EV_COMPLETE) |-> phase_q == PH_DONE)
    else $error("completion emitted while not done");

  a_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_START |-> {1'b0, cnt_q} < ring_n)
    else $error("start walk ran past the ring size");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives reduce starts and packet arrivals through the ring reduce tracker,
// predicts every send command and completion it owes, checks them in order
// ----------------------------------------------------------------------------
module testbench;
  import rrpt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 35;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned NumFixed   = 6;
  localparam int unsigned NumOpening = 15;

  // one result transfer of the tracker
  typedef struct packed {
    logic             ev;
    logic [RankW-1:0] sender;
    logic [RankW-1:0] target;
    logic [StepW-1:0] step;
    logic [FlowW-1:0] flow;
    logic             last;
  } reduce_event_t;

  // one input transfer, optionally with its results typed in by hand
  typedef struct {
    opcode_e           op;
    logic [RankW-1:0]  dest;
    logic [BytesW-1:0] eff;
    logic [BytesW-1:0] pkt;
    bit                typed;
    int unsigned       n_typed;
    reduce_event_t     typed_ev;
  } stim_row_t;

  typedef struct {
    logic [RingW-1:0]  ranks;
    logic [BytesW-1:0] seg;
    logic [RankW-1:0]  root;
    logic [FlowW-1:0]  base;
  } ring_setting_t;

  localparam reduce_event_t NoEvent    = '0;
  localparam reduce_event_t ReduceDone = '{ev: EV_COMPLETE, sender: '0, target: '0,
                                           step: '0, flow: '0, last: 1'b1};

  // directed opening, run with the reset settings: two ranks, one byte per
  // step, root zero, base flow one
  stim_row_t opening_rows [NumOpening] = '{
    '{OP_DATA,   6'd0,  32'd5,          32'd0,          1'b1, 0, NoEvent},    // packet while idle
    '{OP_OTHER,  6'd63, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 0, NoEvent},    // non-data packet
    '{OP_UNUSED, 6'd0,  32'd1,          32'd1,          1'b1, 0, NoEvent},    // unused code
    '{OP_START,  6'd0,  32'd0,          32'd0,          1'b0, 0, NoEvent},    // both step-0 sends
    '{OP_DATA,   6'd2,  32'd1,          32'd0,          1'b1, 0, NoEvent},    // first rank past the ring
    '{OP_DATA,   6'd63, 32'hFFFF_FFFF,  32'd0,          1'b1, 0, NoEvent},    // top rank, outside ring
    '{OP_DATA,   6'd1,  32'd0,          32'd0,          1'b1, 0, NoEvent},    // zero bytes, no step
    '{OP_OTHER,  6'd1,  32'd9,          32'd9,          1'b1, 0, NoEvent},    // non-data mid-run
    '{OP_DATA,   6'd1,  32'd0,          32'd7,          1'b1, 0, NoEvent},    // packet size used, rank 1 done
    '{OP_DATA,   6'd1,  32'd3,          32'd3,          1'b1, 0, NoEvent},    // rank already done
    '{OP_DATA,   6'd0,  32'hFFFF_FFFF,  32'd0,          1'b1, 1, ReduceDone}, // root done, reduce complete
    '{OP_DATA,   6'd0,  32'd1,          32'd1,          1'b1, 0, NoEvent},    // packet after completion
    '{OP_START,  6'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 0, NoEvent},    // restart from done
    '{OP_DATA,   6'd0,  32'd0,          32'hFFFF_FFFF,  1'b1, 1, ReduceDone}, // root finishes first
    '{OP_DATA,   6'd1,  32'd1,          32'd0,          1'b1, 0, NoEvent}     // ignored once done
  };

  // settings of the first phases, the rest are drawn at random
  ring_setting_t fixed_settings [NumFixed] = '{
    '{7'd3,   32'd100,       6'd2,  16'hFFFF},  // flow id wraps on step one
    '{7'd0,   32'd0,         6'd1,  16'h0000},  // ring clamps to two, every packet steps
    '{7'd127, 32'hFFFF_FFFF, 6'd63, 16'h8000},  // ring clamps to 64, counters saturate
    '{7'd4,   32'd5,         6'd10, 16'h00A5},  // root outside the ring
    '{7'd1,   32'd2,         6'd0,  16'h7FFF},  // ring clamps to two
    '{7'd64,  32'd1,         6'd0,  16'h1234}   // full ring
  };

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode   = OP_OTHER;
  logic [RankW-1:0]  dest     = '0;
  logic [BytesW-1:0] eff      = '0;
  logic [BytesW-1:0] pkt      = '0;

  // result channel
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic              event_res;
  logic [RankW-1:0]  sender_rank;
  logic [RankW-1:0]  target_rank;
  logic [StepW-1:0]  step_index;
  logic [FlowW-1:0]  flow_id;
  logic              last_of_run;

  // register write channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_NUM_RANKS;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // predictor copy of the registers, at their reset values
  logic [RingW-1:0]  cfg_ranks = 7'd2;
  logic [BytesW-1:0] cfg_seg   = 32'd1;
  logic [RankW-1:0]  cfg_root  = '0;
  logic [FlowW-1:0]  cfg_base  = 16'd1;

  // predictor copy of the per-rank store
  logic [BytesW-1:0] rank_bytes [MaxRanks];
  logic [7:0]        rank_steps [MaxRanks];
  phase_e            run_state = PH_IDLE;

  reduce_event_t pending_events [$];
  reduce_event_t fresh_events   [$];
  reduce_event_t head_event;

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_mode     = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_tick     = 0;
  int unsigned n_starts    = 0;
  int unsigned n_counted   = 0;
  int unsigned n_saturated = 0;
  int unsigned n_sends     = 0;
  int unsigned n_completes = 0;

  ring_reduce_progress_tracker_core i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (opcode),
    .dest_rank_i       (dest),
    .effective_bytes_i (eff),
    .packet_bytes_i    (pkt),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .event_res_o       (event_res),
    .sender_rank_o     (sender_rank),
    .target_rank_o     (target_rank),
    .step_index_o      (step_index),
    .flow_id_o         (flow_id),
    .last_of_run_o     (last_of_run),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ring size as the block sees it: clamped to 2..MaxRanks
  function automatic int unsigned ring_ranks();
    int unsigned n;
    n = int'(cfg_ranks);
    if (n < 2) n = 2;
    if (n > MaxRanks) n = MaxRanks;
    return n;
  endfunction

  // send command of one rank toward its counterclockwise neighbour
  function automatic reduce_event_t send_cmd(int unsigned rank, int unsigned n,
                                             int unsigned step, bit last);
    reduce_event_t e;
    e.ev     = EV_SEND;
    e.sender = RankW'(rank);
    e.target = RankW'((rank + n - 1) % n);
    e.step   = StepW'(step);
    e.flow   = cfg_base + FlowW'(step);
    e.last   = last;
    return e;
  endfunction

  // advances the predicted progress by one input item and leaves the
  // results it owes in fresh_events
  function automatic void track_item(opcode_e op, logic [RankW-1:0] rank,
                                     logic [BytesW-1:0] eff_in,
                                     logic [BytesW-1:0] pkt_in);
    int unsigned n;
    int unsigned total;
    int unsigned next_step;
    logic [BytesW-1:0] bytes;
    logic [BytesW:0]   sum;
    fresh_events.delete();
    n     = ring_ranks();
    total = n - 1;
    if (op == OP_START) begin
      // a start restarts from any phase
      foreach (rank_bytes[r]) begin
        rank_bytes[r] = '0;
        rank_steps[r] = '0;
      end
      run_state = PH_RUNNING;
      for (int unsigned r = 0; r < n; r++) begin
        fresh_events.push_back(send_cmd(r, n, 0, r == n - 1));
      end
      n_starts++;
      return;
    end
    if (op != OP_DATA || run_state != PH_RUNNING) return;
    if (int'(rank) >= n || int'(rank_steps[rank]) >= total) return;
    n_counted++;
    // zero effective size falls back to the raw packet size
    bytes = (eff_in == '0) ? pkt_in : eff_in;
    sum   = {1'b0, rank_bytes[rank]} + {1'b0, bytes};
    if (sum[BytesW]) begin
      sum = {1'b0, {BytesW{1'b1}}};
      n_saturated++;
    end
    if (sum[BytesW-1:0] < cfg_seg) begin
      rank_bytes[rank] = sum[BytesW-1:0];
      return;
    end
    rank_bytes[rank] = '0;
    next_step        = int'(rank_steps[rank]) + 1;
    rank_steps[rank] = 8'(next_step);
    if (next_step < total) begin
      fresh_events.push_back(send_cmd(int'(rank), n, next_step, 1'b1));
      return;
    end
    if (int'(cfg_root) < n && int'(rank_steps[cfg_root]) >= total) begin
      run_state = PH_DONE;
      fresh_events.push_back(ReduceDone);
    end
  endfunction

  // one input transfer; valid is left high for a back-to-back follower
  task automatic feed_item(stim_row_t row);
    in_valid <= 1'b1;
    opcode   <= row.op;
    dest     <= row.dest;
    eff      <= row.eff;
    pkt      <= row.pkt;
    do @(posedge clk); while (!in_ready);
    track_item(row.op, row.dest, row.eff, row.pkt);
    if (row.typed) begin
      for (int unsigned i = 0; i < row.n_typed; i++) pending_events.push_back(row.typed_ev);
    end else begin
      foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
    end
  endtask

  // sender works in bursts with random gaps in between
  task automatic sender_idle();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // hold the sender until every owed result is out, then let a packet that
  // owes nothing finish its read-modify-write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one register transfer; valid stays high for the next write
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUM_RANKS: cfg_ranks = value[RingW-1:0];
      CFG_SEGMENT:   cfg_seg   = value[BytesW-1:0];
      CFG_ROOT_RANK: cfg_root  = value[RankW-1:0];
      CFG_BASE_FLOW: cfg_base  = value[FlowW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(ring_setting_t s);
    drain();
    write_reg(CFG_NUM_RANKS, CfgDataW'(s.ranks));
    write_reg(CFG_SEGMENT,   CfgDataW'(s.seg));
    write_reg(CFG_ROOT_RANK, CfgDataW'(s.root));
    write_reg(CFG_BASE_FLOW, CfgDataW'(s.base));
    cfg_valid <= 1'b0;
  endtask

  // random traffic of one phase: mostly packets to ranks in the ring, sized
  // so that steps keep advancing, with noise, stray ranks and restarts
  task automatic run_phase_items(int unsigned budget);
    int unsigned counted;
    int unsigned n;
    int unsigned cap;
    int unsigned sel;
    bit          paused;
    stim_row_t   row;
    counted = 0;
    paused  = 1'b0;
    while (counted < budget) begin
      n   = ring_ranks();
      cap = (cfg_seg == '0) ? 4 : ((cfg_seg > 32'h10_0000) ? 32'h10_0000 : int'(cfg_seg));
      sel = $urandom_range(0, 99);
      row.typed    = 1'b0;
      row.n_typed  = 0;
      row.typed_ev = NoEvent;
      row.op       = OP_DATA;
      row.eff      = '0;
      row.pkt      = $urandom;
      if (sel < 3) begin
        row.op   = OP_START;
        row.dest = RankW'($urandom);
        row.eff  = $urandom;
      end else if (sel < 11) begin
        row.op   = opcode_e'($urandom_range(int'(OP_OTHER), int'(OP_UNUSED)));
        row.dest = RankW'($urandom);
        row.eff  = $urandom;
      end else if (sel < 17) begin
        row.dest = RankW'($urandom_range(0, MaxRanks - 1));
      end else if (int'(cfg_root) < n && $urandom_range(0, 9) < 4) begin
        row.dest = cfg_root;
      end else begin
        row.dest = RankW'($urandom_range(0, n - 1));
      end
      if (row.op == OP_DATA) begin
        case ($urandom_range(0, 9))
          0: begin
            row.eff = '0;
            row.pkt = $urandom_range(0, 2 * cap);
          end
          1:       row.eff = $urandom;
          default: row.eff = $urandom_range(1, cap);
        endcase
      end
      feed_item(row);
      if (row.op == OP_START || row.op == OP_DATA) counted++;
      if (!paused && counted >= budget / 2) begin
        paused = 1'b1;
        drain();
      end else begin
        sender_idle();
      end
    end
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // result check against the oldest owed result
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result transfer: event_res %0d sender_rank %0d step_index %0d",
               event_res, sender_rank, step_index);
        errors++;
      end else begin
        head_event = pending_events.pop_front();
        compare_field("event_res",   32'(head_event.ev),     32'(event_res));
        compare_field("sender_rank", 32'(head_event.sender), 32'(sender_rank));
        compare_field("target_rank", 32'(head_event.target), 32'(target_rank));
        compare_field("step_index",  32'(head_event.step),   32'(step_index));
        compare_field("flow_id",     32'(head_event.flow),   32'(flow_id));
        compare_field("last_of_run", 32'(head_event.last),   32'(last_of_run));
        if (head_event.ev == EV_COMPLETE) n_completes++;
        else n_sends++;
      end
    end
  end

  // receiver stalls in modes that are drawn anew when the current one runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 80);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= (rx_tick % 3 == 0);
    endcase
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    ring_setting_t s;
    stim_row_t     kickoff;
    foreach (rank_bytes[r]) begin
      rank_bytes[r] = '0;
      rank_steps[r] = '0;
    end
    kickoff = '{OP_START, '0, '0, '0, 1'b0, 0, NoEvent};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset settings
    foreach (opening_rows[i]) begin
      feed_item(opening_rows[i]);
      sender_idle();
    end

    // phases, each behind a fresh set of register writes: fixed first, then random
    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p < NumFixed) begin
        s = fixed_settings[p];
      end else begin
        s.ranks = RingW'($urandom_range(2, 8));
        s.seg   = $urandom_range(1, 200);
        s.root  = ($urandom_range(0, 3) == 0) ? RankW'($urandom)
                                              : RankW'($urandom_range(0, int'(s.ranks) - 1));
        s.base  = FlowW'($urandom);
      end
      apply_setting(s);
      feed_item(kickoff);
      sender_idle();
      run_phase_items(PhaseItems);
    end

    drain();
    repeat (24) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d results never arrived", pending_events.size());
      errors++;
    end

    $display("covered %0d starts and %0d counted packets (%0d saturating the counter)",
             n_starts, n_counted, n_saturated);
    $display("checked %0d send commands and %0d completions over %0d cycles",
             n_sends, n_completes, cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
